>>> sv/skht_pkg.sv
// Shared types, codes and constants of the string-key hash table.
// Used by skht_front, skht_queue, skht_back and the top level.
`default_nettype none

package skht_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 101;
  localparam int unsigned MAX_PROBES_DEF  = 20;
  localparam int unsigned KEY_CHARS_DEF   = 15;

  localparam int unsigned HASH_MULT = 19;
  localparam int unsigned PROBE_LIN = 23;

  localparam int unsigned SLOT_W         = 7;
  localparam int unsigned OCC_W          = 7;
  localparam int unsigned KEY_LOW_W      = 64;
  localparam int unsigned KEY_HIGH_W     = 56;
  localparam int unsigned KEY_BITS_MAX   = KEY_LOW_W + KEY_HIGH_W;
  localparam int unsigned SLOT_IDX_MAX_W = 10;  // enough for the largest table
  localparam int unsigned CPOS_W         = 4;
  localparam int unsigned WSUM_W         = 15;
  localparam int unsigned PROD_W         = 20;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_DEL   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_READ      = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        char_code;
    logic              last_char;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_W-1:0]     slot;
    logic [OCC_W-1:0]      occupied_count;
    logic [KEY_LOW_W-1:0]  key_low;
    logic [KEY_HIGH_W-1:0] key_high;
    logic                  key_valid;
  } res_t;

  // Request passed from the front to the back.
  typedef struct packed {
    mode_e                     op;
    logic [KEY_BITS_MAX-1:0]   key;
    logic [SLOT_IDX_MAX_W-1:0] home;
    logic [SLOT_W-1:0]         idx;
    logic                      empty;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/string_key_hash_table_probing.sv
// String-key hash table with quadratic probing: key characters arrive one per
// request; add, delete, clear and read of a table of TableSlots keys. A request
// is taken when start is high and busy is low. On the last character of an add
// or delete the front is busy forming the home slot (multiply by 19, reciprocal
// multiply for the quotient, remainder, push); the request then waits in a
// two-entry queue for the back, which probes one slot per cycle through the key
// memory read port. Each result appears on res_o for exactly one cycle with
// done_o high; the receiver cannot stall it. Results come in request order.
// Depends on skht_pkg, skht_front, skht_queue and skht_back.
`default_nettype none

module string_key_hash_table_probing #(
  parameter int unsigned TableSlots = skht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned MaxProbes  = skht_pkg::MAX_PROBES_DEF,
  parameter int unsigned KeyChars   = skht_pkg::KEY_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  skht_pkg::req_t req_i,
  output logic           done_o,
  output skht_pkg::res_t res_o
);
  import skht_pkg::*;

  logic push;
  cmd_t push_data;
  logic q_full;
  logic pop;
  logic q_empty;
  cmd_t pop_data;

  skht_front #(
    .TableSlots(TableSlots),
    .KeyChars  (KeyChars)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .push_o     (push),
    .push_data_o(push_data),
    .q_full_i   (q_full)
  );

  skht_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_data_o (pop_data)
  );

  skht_back #(
    .TableSlots(TableSlots),
    .MaxProbes (MaxProbes),
    .KeyChars  (KeyChars)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (pop_data),
    .pop_o    (pop),
    .done_o   (done_o),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

>>> sv/skht_front.sv
// Front end: gathers key characters, hashes the finished key to its home slot
// and pushes requests to the queue. Depends on skht_pkg.
`default_nettype none

module skht_front #(
  parameter int unsigned TableSlots = skht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KeyChars   = skht_pkg::KEY_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  skht_pkg::req_t req_i,
  output logic           push_o,
  output skht_pkg::cmd_t push_data_o,
  input  logic           q_full_i
);
  import skht_pkg::*;

  localparam int unsigned IW     = $clog2(TableSlots);
  localparam int unsigned KW     = 8 * KeyChars;
  localparam int unsigned RCP_SH = PROD_W + IW;
  localparam int unsigned RCP_W  = PROD_W + 1;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_SH) + 64'(TableSlots) - 64'd1) / 64'(TableSlots);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_QUO, F_REM, F_PUSH} fstate_e;

  fstate_e                 fst_q;
  logic [KW-1:0]           gath_q;
  logic [CPOS_W-1:0]       cpos_q;
  logic [WSUM_W-1:0]       wsum_q;
  logic [KEY_BITS_MAX-1:0] key_q;
  mode_e                   op_q;
  logic                    empty_q;
  logic [WSUM_W-1:0]       hsum_q;
  logic [PROD_W-1:0]       prod_q;
  logic [PROD_W-1:0]       quo_q;
  logic [IW-1:0]           rem_q;

  mode_e                   mode;
  logic                    accept;
  logic                    is_key_op;
  logic                    take_ch;
  logic [CPOS_W-1:0]       cpos_upd;
  logic [KW-1:0]           gath_upd;
  logic [WSUM_W-1:0]       wsum_upd;
  logic [11:0]             wprod;
  logic [PROD_W+RCP_W-1:0] quo_full;
  logic [PROD_W-1:0]       quo_mul;
  logic [PROD_W-1:0]       rem_full;

  assign busy      = (fst_q != F_IDLE) || q_full_i;
  assign mode      = mode_e'(req_i.mode);
  assign accept    = start && !busy;
  assign is_key_op = (mode == MODE_ADD) || (mode == MODE_DEL);
  assign take_ch   = (req_i.char_code != 8'd0) && (cpos_q < CPOS_W'(KeyChars));
  assign wprod     = 12'(req_i.char_code) * 12'(cpos_q + CPOS_W'(1));

  always_comb begin
    gath_upd = gath_q;
    cpos_upd = cpos_q;
    wsum_upd = wsum_q;
    if (take_ch) begin
      gath_upd[8*cpos_q +: 8] = req_i.char_code;
      cpos_upd = cpos_q + CPOS_W'(1);
      wsum_upd = wsum_q + WSUM_W'(wprod);
    end
  end

  // Quotient by reciprocal multiply, exact for any PROD_W-bit product;
  // the quotient is registered in F_QUO and the remainder after it in F_REM.
  assign quo_full = (PROD_W+RCP_W)'(prod_q) * (PROD_W+RCP_W)'(RCP_M);
  assign quo_mul  = quo_q * PROD_W'(TableSlots);
  assign rem_full = prod_q - quo_mul;

  always_comb begin
    push_o            = 1'b0;
    push_data_o       = '0;
    push_data_o.op    = mode;
    push_data_o.idx   = req_i.slot_index;
    if (fst_q == F_IDLE && accept && !is_key_op) begin
      push_o = 1'b1;
    end else if (fst_q == F_PUSH && !q_full_i) begin
      push_o            = 1'b1;
      push_data_o.op    = op_q;
      push_data_o.key   = key_q;
      push_data_o.home  = SLOT_IDX_MAX_W'(rem_q);
      push_data_o.empty = empty_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q   <= F_IDLE;
      gath_q  <= '0;
      cpos_q  <= '0;
      wsum_q  <= '0;
      key_q   <= '0;
      op_q    <= MODE_ADD;
      empty_q <= 1'b0;
      hsum_q  <= '0;
      prod_q  <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
    end else begin
      unique case (fst_q)
        F_IDLE: begin
          if (accept && is_key_op) begin
            if (req_i.last_char) begin
              key_q   <= KEY_BITS_MAX'(gath_upd);
              op_q    <= mode;
              empty_q <= (cpos_upd == '0);
              hsum_q  <= wsum_upd;
              gath_q  <= '0;
              cpos_q  <= '0;
              wsum_q  <= '0;
              fst_q   <= F_MUL;
            end else begin
              gath_q <= gath_upd;
              cpos_q <= cpos_upd;
              wsum_q <= wsum_upd;
            end
          end
        end
        F_MUL: begin
          prod_q <= PROD_W'(hsum_q) * PROD_W'(HASH_MULT);
          fst_q  <= F_QUO;
        end
        F_QUO: begin
          quo_q <= PROD_W'(quo_full >> RCP_SH);
          fst_q <= F_REM;
        end
        F_REM: begin
          rem_q <= rem_full[IW-1:0];
          fst_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full_i) begin
            fst_q <= F_IDLE;
          end
        end
        default: begin
          fst_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/skht_queue.sv
// Short request queue between the front and the back.
// Depends on skht_pkg.
`default_nettype none

module skht_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  skht_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output skht_pkg::cmd_t pop_data_o
);
  import skht_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             ent_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = ent_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/skht_back.sv
// Back end: key memory, slot valid bits and the probe sequencer that carries
// out add, delete, clear and read requests. Depends on skht_pkg.
`default_nettype none

module skht_back #(
  parameter int unsigned TableSlots = skht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned MaxProbes  = skht_pkg::MAX_PROBES_DEF,
  parameter int unsigned KeyChars   = skht_pkg::KEY_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  skht_pkg::cmd_t q_data_i,
  output logic           pop_o,
  output logic           done_o,
  output skht_pkg::res_t res_o
);
  import skht_pkg::*;

  localparam int unsigned IW     = $clog2(TableSlots);
  localparam int unsigned KW     = 8 * KeyChars;
  localparam int unsigned IDX_W  = ((IW > SLOT_W) ? IW : SLOT_W) + 1;
  localparam int unsigned CNT_W  = $clog2(TableSlots + 1);
  localparam int unsigned PRB_W  = $clog2(MaxProbes + 1);
  localparam int unsigned DELTA0 = (1 + PROBE_LIN) % TableSlots;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PROBE, S_FINISH} bstate_e;

  logic [KW-1:0] key_mem [TableSlots];
  logic [KW-1:0] rdata_q;

  bstate_e           st_q;
  logic [TableSlots-1:0] valid_q;
  logic [CNT_W-1:0]  count_q;
  mode_e             op_q;
  logic [KW-1:0]     key_q;
  logic [SLOT_W-1:0] idx_q;
  logic [IW-1:0]     pos_q;
  logic [IW-1:0]     dlt_q;
  logic [PRB_W-1:0]  issue_q;
  logic              rd_vld_q;
  logic              rd_sv_q;
  logic              rd_last_q;
  logic [IW-1:0]     rd_pos_q;
  logic              found_q;
  logic [IW-1:0]     found_pos_q;
  logic              free_q;
  logic [IW-1:0]     free_pos_q;

  logic [IW:0]             pos_sum;
  logic [IW:0]             pos_nxt;
  logic [IW:0]             dlt_sum;
  logic [IW:0]             dlt_nxt;
  logic [IDX_W-1:0]        idx_ext;
  logic                    idx_ok;
  logic [IW-1:0]           raddr;
  logic                    hit;
  logic                    mem_we;
  logic [KEY_BITS_MAX-1:0] key_ext;
  logic                    done_d;
  res_t                    rd_res;

  function automatic res_t mk_res(status_e st, logic [SLOT_W-1:0] slot,
                                  logic [CNT_W-1:0] cnt);
    res_t r;
    r                = '0;
    r.status         = st;
    r.slot           = slot;
    r.occupied_count = OCC_W'(cnt);
    return r;
  endfunction

  // Probe step j adds 2j+24, kept as a running offset below the table size.
  assign pos_sum = {1'b0, pos_q} + {1'b0, dlt_q};
  assign pos_nxt = (pos_sum >= (IW+1)'(TableSlots)) ? pos_sum - (IW+1)'(TableSlots) : pos_sum;
  assign dlt_sum = {1'b0, dlt_q} + (IW+1)'(2);
  assign dlt_nxt = (dlt_sum >= (IW+1)'(TableSlots)) ? dlt_sum - (IW+1)'(TableSlots) : dlt_sum;

  assign idx_ext = IDX_W'(q_data_i.idx);
  assign idx_ok  = idx_ext < IDX_W'(TableSlots);
  assign raddr   = (st_q == S_IDLE) ? idx_ext[IW-1:0] : pos_q;
  assign hit     = rd_vld_q && rd_sv_q && (rdata_q == key_q);
  assign mem_we  = (st_q == S_FINISH) && (op_q == MODE_ADD) && !found_q && free_q;
  assign key_ext = KEY_BITS_MAX'(rdata_q);
  assign pop_o   = (st_q == S_IDLE) && !q_empty_i;

  // clear and empty-key requests answer straight from idle
  assign done_d = (st_q == S_READ) || (st_q == S_FINISH) ||
                  (pop_o && ((q_data_i.op == MODE_CLEAR) ||
                             ((q_data_i.op != MODE_READ) && q_data_i.empty)));

  always_comb begin
    rd_res           = mk_res(ST_READ, idx_q, count_q);
    rd_res.key_valid = rd_sv_q;
    rd_res.key_low   = rd_sv_q ? key_ext[KEY_LOW_W-1:0] : '0;
    rd_res.key_high  = rd_sv_q ? key_ext[KEY_BITS_MAX-1:KEY_LOW_W] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[free_pos_q] <= key_q;
    end
    rdata_q <= key_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      op_q        <= MODE_ADD;
      key_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      dlt_q       <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_sv_q     <= 1'b0;
      rd_last_q   <= 1'b0;
      rd_pos_q    <= '0;
      found_q     <= 1'b0;
      found_pos_q <= '0;
      free_q      <= 1'b0;
      free_pos_q  <= '0;
      done_o      <= 1'b0;
      res_o       <= '0;
    end else begin
      done_o <= done_d;
      unique case (st_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            op_q  <= q_data_i.op;
            key_q <= q_data_i.key[KW-1:0];
            idx_q <= q_data_i.idx;
            unique case (q_data_i.op) inside
              MODE_CLEAR: begin
                valid_q <= '0;
                count_q <= '0;
                res_o   <= mk_res(ST_CLEARED, '0, '0);
              end
              MODE_READ: begin
                rd_sv_q <= idx_ok && valid_q[idx_ext[IW-1:0]];
                st_q    <= S_READ;
              end
              MODE_ADD, MODE_DEL: begin
                if (q_data_i.empty) begin
                  res_o  <= mk_res((q_data_i.op == MODE_ADD) ? ST_NO_FREE : ST_NOT_FOUND,
                                   '0, count_q);
                end else begin
                  pos_q    <= q_data_i.home[IW-1:0];
                  dlt_q    <= IW'(DELTA0);
                  issue_q  <= '0;
                  rd_vld_q <= 1'b0;
                  found_q  <= 1'b0;
                  free_q   <= 1'b0;
                  st_q     <= S_PROBE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          res_o <= rd_res;
          st_q  <= S_IDLE;
        end
        S_PROBE: begin
          // first empty slot counts only if it comes before a match
          if (rd_vld_q && !rd_sv_q && !free_q) begin
            free_q     <= 1'b1;
            free_pos_q <= rd_pos_q;
          end
          if (hit) begin
            found_q     <= 1'b1;
            found_pos_q <= rd_pos_q;
            rd_vld_q    <= 1'b0;
            st_q        <= S_FINISH;
          end else if (rd_vld_q && rd_last_q) begin
            rd_vld_q <= 1'b0;
            st_q     <= S_FINISH;
          end else if (issue_q < PRB_W'(MaxProbes)) begin
            rd_vld_q  <= 1'b1;
            rd_pos_q  <= pos_q;
            rd_sv_q   <= valid_q[pos_q];
            rd_last_q <= (issue_q == PRB_W'(MaxProbes - 1));
            pos_q     <= pos_nxt[IW-1:0];
            dlt_q     <= dlt_nxt[IW-1:0];
            issue_q   <= issue_q + PRB_W'(1);
          end else begin
            rd_vld_q <= 1'b0;
          end
        end
        S_FINISH: begin
          st_q   <= S_IDLE;
          if (op_q == MODE_ADD) begin
            if (found_q) begin
              res_o <= mk_res(ST_PRESENT, SLOT_W'(found_pos_q), count_q);
            end else if (free_q) begin
              valid_q[free_pos_q] <= 1'b1;
              count_q             <= count_q + CNT_W'(1);
              res_o <= mk_res(ST_INSERTED, SLOT_W'(free_pos_q), count_q + CNT_W'(1));
            end else begin
              res_o <= mk_res(ST_NO_FREE, '0, count_q);
            end
          end else begin
            if (found_q) begin
              valid_q[found_pos_q] <= 1'b0;
              count_q              <= count_q - CNT_W'(1);
              res_o <= mk_res(ST_DELETED, SLOT_W'(found_pos_q), count_q - CNT_W'(1));
            end else begin
              res_o <= mk_res(ST_NOT_FOUND, '0, count_q);
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/string_key_hash_table_probing_tb.sv
// Self-checking testbench for string_key_hash_table_probing: keys are sent a
// character per request, and every result is checked against a table model.
// Depends on skht_pkg and the top level of the block with its submodules.
`timescale 1ns / 1ps

module string_key_hash_table_probing_tb;
  import skht_pkg::*;

  localparam int SLOTS       = TABLE_SLOTS_DEF;
  localparam int PROBES      = MAX_PROBES_DEF;
  localparam int KEY_LEN_MAX = KEY_CHARS_DEF;
  localparam int POOL_KEYS   = 40;
  localparam int CYCLE_LIMIT = 600000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic done_o;
  res_t res_o;

  string_key_hash_table_probing dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #2 clk_i = ~clk_i;

  // table model state
  logic [63:0] tbl_key_lo [SLOTS];
  logic [55:0] tbl_key_hi [SLOTS];
  bit          tbl_used   [SLOTS];
  bit          tbl_written[SLOTS];
  logic [63:0] acc_lo;
  logic [55:0] acc_hi;
  int          acc_pos;
  int          acc_sum;
  int          keys_held;

  res_t expected_results[$];
  res_t check_want;

  int n_errors        = 0;
  int n_items         = 0;
  int results_checked = 0;
  int cycle_count     = 0;
  int idle_pct        = 0;
  int status_seen[8];
  logic [6:0] last_pushed_slot;

  // scratch key and key pool
  logic [7:0] key_buf[18];
  int         key_len;
  logic [7:0] pool_chars[POOL_KEYS][18];
  int         pool_len[POOL_KEYS];

  task automatic table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key_lo[i]  = '0;
      tbl_key_hi[i]  = '0;
      tbl_used[i]    = 1'b0;
      tbl_written[i] = 1'b0;
    end
    acc_lo    = '0;
    acc_hi    = '0;
    acc_pos   = 0;
    acc_sum   = 0;
    keys_held = 0;
  endtask

  // Applies one accepted request to the model; produces is 0 for a plain
  // character request.
  task automatic table_apply(input req_t r, output bit produces, output res_t e);
    logic [63:0] klo;
    logic [55:0] khi;
    bit empty_key;
    int p, home, pos, hit, free_at;
    e = '0;
    produces = 1'b1;
    if (r.mode == MODE_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
      keys_held = 0;
      e.status = ST_CLEARED;
    end else if (r.mode == MODE_READ) begin
      e.status = ST_READ;
      e.slot   = r.slot_index;
      if (r.slot_index < SLOTS && tbl_used[r.slot_index]) begin
        e.key_low   = tbl_key_lo[r.slot_index];
        e.key_high  = tbl_key_hi[r.slot_index];
        e.key_valid = 1'b1;
      end
    end else begin
      if (r.char_code != 8'h00 && acc_pos < KEY_LEN_MAX) begin
        p = acc_pos + 1;
        if (p <= 8) acc_lo[8*(p-1) +: 8] = r.char_code;
        else acc_hi[8*(p-9) +: 8] = r.char_code;
        acc_sum += int'(r.char_code) * p;
        acc_pos = p;
      end
      if (!r.last_char) begin
        produces = 1'b0;
      end else begin
        klo       = acc_lo;
        khi       = acc_hi;
        empty_key = (acc_pos == 0);
        home      = (acc_sum * HASH_MULT) % SLOTS;
        acc_lo    = '0;
        acc_hi    = '0;
        acc_pos   = 0;
        acc_sum   = 0;
        if (empty_key) begin
          e.status = (r.mode == MODE_ADD) ? ST_NO_FREE : ST_NOT_FOUND;
        end else begin
          hit     = -1;
          free_at = -1;
          for (int j = 0; j < PROBES && hit < 0; j++) begin
            pos = (home + j * j + PROBE_LIN * j) % SLOTS;
            if (tbl_used[pos]) begin
              if (tbl_key_lo[pos] == klo && tbl_key_hi[pos] == khi) hit = pos;
            end else if (free_at < 0) begin
              free_at = pos;
            end
          end
          if (r.mode == MODE_ADD) begin
            if (hit >= 0) begin
              e.status = ST_PRESENT;
              e.slot   = 7'(hit);
            end else if (free_at >= 0) begin
              tbl_key_lo[free_at]  = klo;
              tbl_key_hi[free_at]  = khi;
              tbl_used[free_at]    = 1'b1;
              tbl_written[free_at] = 1'b1;
              keys_held++;
              e.status = ST_INSERTED;
              e.slot   = 7'(free_at);
            end else begin
              e.status = ST_NO_FREE;
            end
          end else if (hit >= 0) begin
            tbl_used[hit] = 1'b0;
            keys_held--;
            e.status = ST_DELETED;
            e.slot   = 7'(hit);
          end else begin
            e.status = ST_NOT_FOUND;
          end
        end
      end
    end
    e.occupied_count = 7'(keys_held);
  endtask

  task automatic report_mismatch(input string msg);
    if (n_errors < 50) $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // results cannot be held off, so every strobe is checked on the spot
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        check_want = expected_results.pop_front();
        check_field("status", res_o.status, check_want.status);
        check_field("slot", res_o.slot, check_want.slot);
        check_field("occupied_count", res_o.occupied_count, check_want.occupied_count);
        check_field("key_low", res_o.key_low, check_want.key_low);
        check_field("key_high", res_o.key_high, check_want.key_high);
        check_field("key_valid", res_o.key_valid, check_want.key_valid);
        status_seen[check_want.status]++;
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int g;
    g = 0;
    if (idle_pct == 0) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(45, 1);
    while ($urandom_range(99) < idle_pct && g < 8) g++;
    return g;
  endfunction

  // Mostly reads back slots that have held a key at some point, else an index past the table.
  function automatic logic [6:0] pick_read_index();
    int i;
    if ($urandom_range(4) != 0) begin
      for (int tries = 0; tries < 200; tries++) begin
        i = $urandom_range(SLOTS - 1);
        if (tbl_written[i]) return 7'(i);
      end
    end
    return 7'($urandom_range(127, SLOTS));
  endfunction

  // Sends one request and waits until it is taken; called at a rising edge.
  task automatic send_req(input logic [1:0] m, input logic [7:0] ch, input logic lc,
                          input logic [6:0] idx);
    req_t r;
    res_t e;
    bit got;
    int gap;
    r.mode       = m;
    r.char_code  = ch;
    r.last_char  = lc;
    r.slot_index = idx;
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    table_apply(r, got, e);
    if (got) begin
      expected_results.push_back(e);
      last_pushed_slot = e.slot;
    end
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sends key_buf; the last request carries the operation. Noise puts in zero
  // characters, reads and other modes ahead of characters, or ends the key on a zero.
  task automatic send_key(input logic [1:0] m, input bit noisy);
    logic [1:0] lead;
    for (int i = 0; i < key_len; i++) begin
      lead = (noisy && $urandom_range(3) == 0) ? 2'($urandom_range(1)) : m;
      if (noisy && $urandom_range(9) == 0)
        send_req(lead, 8'h00, 1'b0, 7'($urandom_range(127)));
      if (noisy && $urandom_range(19) == 0)
        send_req(MODE_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 pick_read_index());
      if (i < key_len - 1) begin
        send_req(lead, key_buf[i], 1'b0, 7'($urandom_range(127)));
      end else if (noisy && $urandom_range(7) == 0) begin
        send_req(lead, key_buf[i], 1'b0, 7'($urandom_range(127)));
        send_req(m, 8'h00, 1'b1, 7'($urandom_range(127)));
      end else begin
        send_req(m, key_buf[i], 1'b1, 7'($urandom_range(127)));
      end
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_req(MODE_READ, 8'h00, 1'b0, 7'd127);     // out of range, empty table
    send_req(MODE_ADD, 8'h00, 1'b1, 7'd0);        // empty key add
    send_req(MODE_DEL, 8'h00, 1'b1, 7'd55);       // empty key delete
    send_req(MODE_ADD, 8'h01, 1'b1, 7'd0);
    send_req(MODE_ADD, 8'h01, 1'b1, 7'd0);        // already present
    send_req(MODE_READ, 8'hff, 1'b1, last_pushed_slot);
    // 16 characters: the last one lies beyond the key length
    key_len = 16;
    for (int i = 0; i < 16; i++) key_buf[i] = (i % 3 == 0) ? 8'hff : 8'($urandom_range(254, 1));
    send_key(MODE_ADD, 1'b0);
    send_req(MODE_READ, 8'h00, 1'b0, last_pushed_slot);
    // mode of the last character decides
    send_req(MODE_DEL, 8'hff, 1'b0, 7'd0);
    send_req(MODE_ADD, 8'h01, 1'b1, 7'd0);
    // read and clear in the middle of a key leave the gather intact
    send_req(MODE_ADD, 8'h02, 1'b0, 7'd0);
    send_req(MODE_READ, 8'h00, 1'b1, pick_read_index());
    send_req(MODE_CLEAR, 8'h44, 1'b1, 7'd127);
    send_req(MODE_ADD, 8'h00, 1'b0, 7'd0);
    send_req(MODE_ADD, 8'h03, 1'b1, 7'd0);
    send_req(MODE_DEL, 8'h02, 1'b0, 7'd0);
    send_req(MODE_DEL, 8'h03, 1'b1, 7'd0);
  endtask

  // Two-character keys of one weighted sum share a home slot and so a probe
  // chain; enough of them run out of free probes.
  task automatic chain_key(input int wsum, input int c2);
    key_buf[0] = 8'(wsum - 2 * c2);
    key_buf[1] = 8'(c2);
    key_len    = 2;
  endtask

  task automatic test_probe_chain();
    int wsum, lo, hi, base;
    send_req(MODE_CLEAR, 8'h00, 1'b0, 7'd0);
    wsum = $urandom_range(380, 260);
    lo   = (wsum - 254) / 2;
    hi   = (wsum - 1) / 2;
    base = lo + $urandom_range(hi - lo - 26);
    for (int k = 0; k < 26; k++) begin
      chain_key(wsum, base + k);
      send_key(MODE_ADD, 1'b0);
    end
    chain_key(wsum, base + 3);
    send_key(MODE_DEL, 1'b0);
    chain_key(wsum, base + 11);
    send_key(MODE_DEL, 1'b0);
    chain_key(wsum, base + 25);
    send_key(MODE_ADD, 1'b0);
    chain_key(wsum, base + 17);
    send_key(MODE_DEL, 1'b0);
    chain_key(wsum, base + 5);
    send_key(MODE_ADD, 1'b0);
    chain_key(wsum, base + 11);
    send_key(MODE_DEL, 1'b0);
    for (int k = 0; k < 4; k++) send_req(MODE_READ, 8'h00, 1'b0, pick_read_index());
  endtask

  task automatic build_pool();
    int dice;
    for (int k = 0; k < POOL_KEYS; k++) begin
      dice = $urandom_range(9);
      pool_len[k] = (dice < 7) ? $urandom_range(4, 1) :
                    (dice < 9) ? $urandom_range(12, 5) : $urandom_range(18, 13);
      for (int i = 0; i < 18; i++) pool_chars[k][i] = 8'($urandom_range(255, 1));
    end
  endtask

  task automatic load_pool_key(input int k);
    key_len = pool_len[k];
    for (int i = 0; i < 18; i++) key_buf[i] = pool_chars[k][i];
  endtask

  task automatic random_op();
    int dice, burst;
    dice = $urandom_range(99);
    if (dice < 52) begin
      load_pool_key($urandom_range(POOL_KEYS - 1));
      send_key(MODE_ADD, $urandom_range(3) == 0);
    end else if (dice < 75) begin
      if ($urandom_range(9) < 7) begin
        load_pool_key($urandom_range(POOL_KEYS - 1));
      end else begin
        key_len = $urandom_range(6, 1);
        for (int i = 0; i < key_len; i++) key_buf[i] = 8'($urandom_range(255, 1));
      end
      send_key(MODE_DEL, $urandom_range(3) == 0);
    end else if (dice < 84) begin
      send_req(MODE_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), pick_read_index());
    end else if (dice < 86) begin
      send_req(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
               7'($urandom_range(127)));
    end else if (dice < 87) begin
      wait_drained();
    end else begin
      burst = $urandom_range(5, 1);
      for (int i = 0; i < burst; i++)
        send_req(2'($urandom_range(1)), 8'($urandom_range(255)), $urandom_range(2) == 0,
                 7'($urandom_range(127)));
    end
  endtask

  task automatic test_random();
    int pcts[4];
    int stop_at;
    pcts = '{0, 62, 0, 33};
    build_pool();
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      stop_at  = n_items + 165;
      while (n_items < stop_at) random_op();
      wait_drained();
    end
    idle_pct = 0;
  endtask

  initial begin
    table_reset();
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_probe_chain();
    wait_drained();
    test_random();
    repeat (80) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked in %0d cycles",
             n_items, results_checked, cycle_count);
    $display({"outcomes: inserted %0d, present %0d, chain full %0d, deleted %0d, ",
              "missing %0d, clears %0d, reads %0d"},
             status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_NO_FREE],
             status_seen[ST_DELETED], status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED],
             status_seen[ST_READ]);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
